/* hw/rtl/rgb565_gray_decimator_defines.svh */
// ----------------------------------------------------------------------------
// RGB565 gray decimator assertion macros
// Clocked assertion helpers shared by the decimator RTL files.
// ----------------------------------------------------------------------------
`ifndef RGB565_GRAY_DECIMATOR_DEFINES_SVH
`define RGB565_GRAY_DECIMATOR_DEFINES_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside of reset.
`define RGD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rgd assertion failed");
// The expression must never be true outside of reset.
`define RGD_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("rgd forbidden condition seen");
`else
`define RGD_ASSERT(lbl, prop)
`define RGD_ASSERT_NEVER(lbl, expr)
`endif

`endif

/* hw/rtl/rgd_pkg.sv */
// ----------------------------------------------------------------------------
// RGB565 gray decimator package
// Register indexes, reset values, shared types and the luma function.
// ----------------------------------------------------------------------------
`default_nettype none

package rgd_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] REG_OUT_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_OUT_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_STEP_X     = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_STEP_Y     = 2'd3;

  localparam logic [7:0] OUT_WIDTH_RST  = 8'd40;
  localparam logic [7:0] OUT_HEIGHT_RST = 8'd30;
  localparam logic [4:0] STEP_X_RST     = 5'd4;
  localparam logic [4:0] STEP_Y_RST     = 5'd4;

  localparam logic [4:0] STEP_MAX = 5'd16;

  localparam logic [7:0] W_RED   = 8'd77;
  localparam logic [7:0] W_GREEN = 8'd150;
  localparam logic [7:0] W_BLUE  = 8'd29;

  typedef struct packed {
    logic [7:0] out_width;
    logic [7:0] out_height;
    logic [4:0] step_x;
    logic [4:0] step_y;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  gray;
    logic [15:0] out_index;
    logic        frame_last;
  } result_t;

  // Channels are widened to 8 bits by replicating their top bits; the weights
  // sum to 256, so the weighted sum always fits in 16 bits.
  function automatic logic [7:0] luma565(input logic [15:0] px);
    logic [7:0]  r8;
    logic [7:0]  g8;
    logic [7:0]  b8;
    logic [15:0] sum;
    r8  = {px[15:11], px[15:13]};
    g8  = {px[10:5], px[10:9]};
    b8  = {px[4:0], px[4:2]};
    sum = 16'(r8) * 16'(W_RED) + 16'(g8) * 16'(W_GREEN) + 16'(b8) * 16'(W_BLUE);
    return sum[15:8];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/rgd_if.sv */
// ----------------------------------------------------------------------------
// RGB565 gray decimator stream interfaces
// Valid/ready channels for incoming pixels and outgoing gray results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgd_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_word;
  logic        frame_start;

  modport source (output valid, output pixel_word, output frame_start, input ready);
  modport sink   (input valid, input pixel_word, input frame_start, output ready);
endinterface

interface rgd_gray_if;
  logic        valid;
  logic        ready;
  logic [7:0]  gray;
  logic [15:0] out_index;
  logic        frame_last;

  modport source (output valid, output gray, output out_index, output frame_last,
                  input ready);
  modport sink   (input valid, input gray, input out_index, input frame_last,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/rgd_pos_ctrl.sv */
// ----------------------------------------------------------------------------
// RGB565 gray decimator position control
// Raster position counters, keep decision, output index and luma.
// ----------------------------------------------------------------------------
`default_nettype none

module rgd_pos_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rgd_pkg::cfg_t   cfg_i,
  input  wire logic            accept_i,
  input  wire logic [15:0]     pixel_word_i,
  input  wire logic            frame_start_i,
  output logic                 keep_o,
  output rgd_pkg::result_t     result_o
);

  logic [7:0]  out_col_q, out_col_d;
  logic [3:0]  sub_col_q, sub_col_d;
  logic [3:0]  sub_row_q, sub_row_d;
  logic [7:0]  out_row_q, out_row_d;
  logic [15:0] write_pos_q, write_pos_d;

  logic [7:0]  w_eff, h_eff;
  logic [4:0]  sx_eff, sy_eff;
  logic [7:0]  col, row;
  logic [3:0]  scol, srow;
  logic [15:0] pos;
  logic        scol_end, col_end, srow_end, row_end;

  always_comb begin
    w_eff = (cfg_i.out_width == 8'd0) ? 8'd1 : cfg_i.out_width;
    h_eff = (cfg_i.out_height == 8'd0) ? 8'd1 : cfg_i.out_height;
    priority if (cfg_i.step_x == 5'd0) begin
      sx_eff = 5'd1;
    end else if (cfg_i.step_x > rgd_pkg::STEP_MAX) begin
      sx_eff = rgd_pkg::STEP_MAX;
    end else begin
      sx_eff = cfg_i.step_x;
    end
    priority if (cfg_i.step_y == 5'd0) begin
      sy_eff = 5'd1;
    end else if (cfg_i.step_y > rgd_pkg::STEP_MAX) begin
      sy_eff = rgd_pkg::STEP_MAX;
    end else begin
      sy_eff = cfg_i.step_y;
    end
  end

  // A frame start clears the position before this pixel is judged.
  always_comb begin
    col  = frame_start_i ? 8'd0  : out_col_q;
    row  = frame_start_i ? 8'd0  : out_row_q;
    scol = frame_start_i ? 4'd0  : sub_col_q;
    srow = frame_start_i ? 4'd0  : sub_row_q;
    pos  = frame_start_i ? 16'd0 : write_pos_q;

    // Compares use ">=" so that a limit lowered mid-frame still wraps.
    scol_end = ({1'b0, scol} + 5'd1) >= sx_eff;
    col_end  = ({1'b0, col} + 9'd1) >= {1'b0, w_eff};
    srow_end = ({1'b0, srow} + 5'd1) >= sy_eff;
    row_end  = ({1'b0, row} + 9'd1) >= {1'b0, h_eff};

    keep_o = (scol == 4'd0) && (srow == 4'd0);

    sub_col_d   = scol;
    out_col_d   = col;
    sub_row_d   = srow;
    out_row_d   = row;
    write_pos_d = keep_o ? pos + 16'd1 : pos;

    if (scol_end) begin
      sub_col_d = 4'd0;
      if (col_end) begin
        out_col_d = 8'd0;
        if (srow_end) begin
          sub_row_d = 4'd0;
          if (row_end) begin
            out_row_d   = 8'd0;
            write_pos_d = 16'd0;
          end else begin
            out_row_d = row + 8'd1;
          end
        end else begin
          sub_row_d = srow + 4'd1;
        end
      end else begin
        out_col_d = col + 8'd1;
      end
    end else begin
      sub_col_d = scol + 4'd1;
    end

    result_o.gray       = rgd_pkg::luma565(pixel_word_i);
    result_o.out_index  = pos;
    result_o.frame_last = col_end && row_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_col_q   <= '0;
      sub_col_q   <= '0;
      sub_row_q   <= '0;
      out_row_q   <= '0;
      write_pos_q <= '0;
    end else if (accept_i) begin
      out_col_q   <= out_col_d;
      sub_col_q   <= sub_col_d;
      sub_row_q   <= sub_row_d;
      out_row_q   <= out_row_d;
      write_pos_q <= write_pos_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rgd_out_buf.sv */
// ----------------------------------------------------------------------------
// RGB565 gray decimator output buffer
// Result register with a skid stage so input acceptance survives a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb565_gray_decimator_defines.svh"

module rgd_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire rgd_pkg::result_t push_data_i,
  output logic                  space_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output rgd_pkg::result_t      out_data_o
);

  logic             out_v_q;
  logic             skid_v_q;
  rgd_pkg::result_t out_q;
  rgd_pkg::result_t skid_q;
  logic             pop;

  assign space_o     = !skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
  assign pop         = out_v_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= push_i;
      end
    end else if (push_i) begin
      if (out_v_q) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= skid_v_q ? skid_q : push_data_i;
    end else if (push_i && !out_v_q) begin
      out_q <= push_data_i;
    end
    if (push_i && out_v_q && !pop) begin
      skid_q <= push_data_i;
    end
  end

  `RGD_ASSERT_NEVER(a_skid_without_out, skid_v_q && !out_v_q)
  `RGD_ASSERT(a_skid_fill_on_stall, $rose(skid_v_q) |-> $past(out_v_q && !out_ready_i))
  `RGD_ASSERT(a_skid_drains_to_out, (pop && skid_v_q) |=> (out_v_q && !skid_v_q))

endmodule

`default_nettype wire

/* hw/rtl/rgb565_gray_decimator.sv */
// ----------------------------------------------------------------------------
// RGB565 gray decimator
// Decimates an RGB565 raster stream and converts kept pixels to 8-bit luma.
// ----------------------------------------------------------------------------
// The block takes one pixel transaction per clock while input ready is high
// and produces a result for every step_x-th pixel of every step_y-th row,
// registered in the output buffer once the pixel is accepted. Position
// counters and the constant-weight luma sum are combinational ahead of the
// result register, so the sustained rate is one pixel per cycle; input ready
// drops only when both entries of the two-entry result buffer are full.
// Configuration writes are meant for idle periods between frames.
`default_nettype none

module rgb565_gray_decimator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rgd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [rgd_pkg::CfgDataW-1:0]  cfg_data_i,
  rgd_pix_if.sink                            in_i,
  rgd_gray_if.source                         out_o
);

  rgd_pkg::cfg_t    cfg_q;
  rgd_pkg::result_t result;
  rgd_pkg::result_t out_data;
  logic             keep;
  logic             space;
  logic             accept;
  logic             out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.out_width  <= rgd_pkg::OUT_WIDTH_RST;
      cfg_q.out_height <= rgd_pkg::OUT_HEIGHT_RST;
      cfg_q.step_x     <= rgd_pkg::STEP_X_RST;
      cfg_q.step_y     <= rgd_pkg::STEP_Y_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rgd_pkg::REG_OUT_WIDTH:  cfg_q.out_width  <= cfg_data_i;
        rgd_pkg::REG_OUT_HEIGHT: cfg_q.out_height <= cfg_data_i;
        rgd_pkg::REG_STEP_X:     cfg_q.step_x     <= cfg_data_i[4:0];
        rgd_pkg::REG_STEP_Y:     cfg_q.step_y     <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = space;
  assign accept     = in_i.valid && space;

  rgd_pos_ctrl u_pos_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .accept_i      (accept),
    .pixel_word_i  (in_i.pixel_word),
    .frame_start_i (in_i.frame_start),
    .keep_o        (keep),
    .result_o      (result)
  );

  rgd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && keep),
    .push_data_i (result),
    .space_o     (space),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  assign out_o.valid      = out_valid;
  assign out_o.gray       = out_data.gray;
  assign out_o.out_index  = out_data.out_index;
  assign out_o.frame_last = out_data.frame_last;

endmodule

`default_nettype wire
